FILE: rtl/core/lr_pkg.sv
// Shared types and constants of the line rasterizer.
`default_nettype none

package lr_pkg;

	// Fixed field widths
	localparam int DIM_W   = 13;
	localparam int PITCH_W = 14;
	localparam int ADDR_W  = 32;
	localparam int COLOR_W = 32;

	// Depth of the command queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Item actions
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_TICK  = 1'b1;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_SCREEN_WIDTH  = 2'd0,
		CFG_SCREEN_HEIGHT = 2'd1,
		CFG_ROW_PITCH     = 2'd2,
		CFG_FRAME_BASE    = 2'd3
	} cfg_reg_t;

	// Register reset values
	localparam logic [DIM_W-1:0]   SCREEN_WIDTH_RST  = 13'd640;
	localparam logic [DIM_W-1:0]   SCREEN_HEIGHT_RST = 13'd480;
	localparam logic [PITCH_W-1:0] ROW_PITCH_RST     = 14'd640;
	localparam logic [ADDR_W-1:0]  FRAME_BASE_RST    = 32'd0;

	// Frame-buffer geometry seen by the back end
	typedef struct packed {
		logic [DIM_W-1:0]   screen_width;
		logic [DIM_W-1:0]   screen_height;
		logic [PITCH_W-1:0] row_pitch_words;
		logic [ADDR_W-1:0]  frame_base;
	} cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/lr_item_if.sv
// Input item channel: start or tick commands with end points and color.
`default_nettype none

interface lr_item_if #(
	parameter int COORD_BITS = 13
);
	logic                         valid;
	logic                         ready;
	logic                         action;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] end_x;
	logic signed [COORD_BITS-1:0] end_y;
	logic [lr_pkg::COLOR_W-1:0]   pixel_color;

	modport source (
		output valid, action, start_x, start_y, end_x, end_y, pixel_color,
		input  ready
	);
	modport sink (
		input  valid, action, start_x, start_y, end_x, end_y, pixel_color,
		output ready
	);
endinterface

`default_nettype wire

FILE: rtl/core/lr_pixel_if.sv
// Output pixel channel: coordinates, word address, color and flags.
`default_nettype none

interface lr_pixel_if #(
	parameter int COORD_BITS = 13
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] pixel_x;
	logic signed [COORD_BITS-1:0] pixel_y;
	logic [lr_pkg::ADDR_W-1:0]    word_address;
	logic [lr_pkg::COLOR_W-1:0]   write_color;
	logic                         visible;
	logic                         last;

	modport source (
		output valid, pixel_x, pixel_y, word_address, write_color, visible, last,
		input  ready
	);
	modport sink (
		input  valid, pixel_x, pixel_y, word_address, write_color, visible, last,
		output ready
	);
endinterface

`default_nettype wire

FILE: rtl/core/lr_cfg_if.sv
// Configuration write channel: register index and write data.
`default_nettype none

interface lr_cfg_if;
	logic                      valid;
	logic                      ready;
	lr_pkg::cfg_reg_t          index;
	logic [lr_pkg::ADDR_W-1:0] data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

`default_nettype wire

FILE: rtl/core/lr_front.sv
// Front end: accepts items and works out line setup (direction, axis lengths).
`default_nettype none

module lr_front #(
	parameter int COORD_BITS = 13
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	lr_item_if.sink                           item,
	output logic                              ent_valid,
	input  wire logic                         ent_ready,
	output logic                              ent_action,
	output logic [COORD_BITS-1:0]             ent_x,
	output logic [COORD_BITS-1:0]             ent_y,
	output logic [COORD_BITS:0]               ent_major,
	output logic [COORD_BITS:0]               ent_minor,
	output logic                              ent_x_neg,
	output logic                              ent_y_neg,
	output logic                              ent_x_major,
	output logic [lr_pkg::COLOR_W-1:0]        ent_color
);

	logic signed [COORD_BITS:0] dx, dy;
	logic [COORD_BITS:0]        adx, ady;
	logic                       load;

	logic                       valid_s1;
	logic                       action_s1;
	logic [COORD_BITS-1:0]      x_s1, y_s1;
	logic [COORD_BITS:0]        lx_s1, ly_s1;
	logic                       xneg_s1, yneg_s1;
	logic [lr_pkg::COLOR_W-1:0] color_s1;

	// Deltas in one extra bit, magnitudes plus one
	always_comb begin
		dx  = $signed({item.end_x[COORD_BITS-1], item.end_x})
			- $signed({item.start_x[COORD_BITS-1], item.start_x});
		dy  = $signed({item.end_y[COORD_BITS-1], item.end_y})
			- $signed({item.start_y[COORD_BITS-1], item.start_y});
		adx = dx[COORD_BITS] ? (COORD_BITS+1)'(0) - dx : dx;
		ady = dy[COORD_BITS] ? (COORD_BITS+1)'(0) - dy : dy;
	end

	assign item.ready = !valid_s1 || ent_ready;
	assign load       = item.valid && item.ready;

	// Stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (ent_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (load) begin
			action_s1 <= item.action;
			x_s1      <= item.start_x;
			y_s1      <= item.start_y;
			lx_s1     <= adx + (COORD_BITS+1)'(1);
			ly_s1     <= ady + (COORD_BITS+1)'(1);
			xneg_s1   <= dx[COORD_BITS];
			yneg_s1   <= dy[COORD_BITS];
			color_s1  <= item.pixel_color;
		end
	end

	// Axis selection toward the queue
	always_comb begin
		ent_valid   = valid_s1;
		ent_action  = action_s1;
		ent_x       = x_s1;
		ent_y       = y_s1;
		ent_x_major = lx_s1 >= ly_s1;
		ent_major   = ent_x_major ? lx_s1 : ly_s1;
		ent_minor   = ent_x_major ? ly_s1 : lx_s1;
		ent_x_neg   = xneg_s1;
		ent_y_neg   = yneg_s1;
		ent_color   = color_s1;
	end

endmodule

`default_nettype wire

FILE: rtl/core/lr_queue.sv
// Small FIFO between the front and back ends.
`default_nettype none

module lr_queue #(
	parameter int WIDTH = 90
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  not_empty
);

	localparam int DEPTH = lr_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full      = count_q == CNT_W'(DEPTH);
	assign not_empty = count_q != '0;
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign rd_data   = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/lr_back.sv
// Back end: line walker, address multiply and address add stages.
`default_nettype none

module lr_back #(
	parameter int COORD_BITS = 13
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire lr_pkg::cfg_t                 cfg,
	input  wire logic                         ent_valid,
	output logic                              ent_pop,
	input  wire logic                         ent_action,
	input  wire logic [COORD_BITS-1:0]        ent_x,
	input  wire logic [COORD_BITS-1:0]        ent_y,
	input  wire logic [COORD_BITS:0]          ent_major,
	input  wire logic [COORD_BITS:0]          ent_minor,
	input  wire logic                         ent_x_neg,
	input  wire logic                         ent_y_neg,
	input  wire logic                         ent_x_major,
	input  wire logic [lr_pkg::COLOR_W-1:0]   ent_color,
	lr_pixel_if.source                        pixel
);

	localparam int C      = COORD_BITS;
	localparam int CMP_W  = ((C > lr_pkg::DIM_W) ? C : lr_pkg::DIM_W) + 1;
	localparam int PROD_W = C + lr_pkg::PITCH_W + 1;
	localparam int AW     = lr_pkg::ADDR_W;

	// Line state
	logic                       active_q;
	logic [C-1:0]               cur_x_q, cur_y_q;
	logic [C:0]                 err_q, left_q, major_q, minor_q;
	logic                       xneg_q, yneg_q, xmaj_q;
	logic [lr_pkg::COLOR_W-1:0] color_q;

	// Pipeline stages
	logic                       valid_s1, valid_s2, valid_s3;
	logic [C-1:0]               x_s1, y_s1, x_s2;
	logic [C-1:0]               y_s2;
	logic [lr_pkg::COLOR_W-1:0] color_s1, color_s2;
	logic                       last_s1, last_s2;
	logic                       vis_s2;
	logic [AW-1:0]              prod_s2;

	logic                       advance, is_start, emit;
	logic [C+1:0]               acc, acc_next;
	logic                       minor_step, fin;
	logic [C-1:0]               x_step, y_step;
	logic signed [PROD_W-1:0]   prod_full;
	logic                       vis;

	assign advance  = !valid_s3 || pixel.ready;
	assign ent_pop  = advance && ent_valid;
	assign is_start = ent_pop && (ent_action == lr_pkg::ACT_START);
	assign emit     = ent_pop && (ent_action == lr_pkg::ACT_TICK) && active_q;

	// Error accumulator and next position
	always_comb begin
		acc        = {1'b0, err_q} + {1'b0, minor_q};
		minor_step = acc >= {1'b0, major_q};
		acc_next   = minor_step ? acc - {1'b0, major_q} : acc;
		fin        = left_q <= (C+1)'(1);
		x_step     = xneg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
		y_step     = yneg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
	end

	// Line state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			err_q    <= '0;
			left_q   <= '0;
			major_q  <= '0;
			minor_q  <= '0;
			xneg_q   <= 1'b0;
			yneg_q   <= 1'b0;
			xmaj_q   <= 1'b1;
			color_q  <= '0;
		end else if (is_start) begin
			active_q <= 1'b1;
			cur_x_q  <= ent_x;
			cur_y_q  <= ent_y;
			err_q    <= '0;
			left_q   <= ent_major;
			major_q  <= ent_major;
			minor_q  <= ent_minor;
			xneg_q   <= ent_x_neg;
			yneg_q   <= ent_y_neg;
			xmaj_q   <= ent_x_major;
			color_q  <= ent_color;
		end else if (emit) begin
			err_q  <= acc_next[C:0];
			left_q <= fin ? '0 : left_q - 1'b1;
			if (fin) begin
				active_q <= 1'b0;
			end
			if (xmaj_q) begin
				cur_x_q <= x_step;
				if (minor_step) begin
					cur_y_q <= y_step;
				end
			end else begin
				cur_y_q <= y_step;
				if (minor_step) begin
					cur_x_q <= x_step;
				end
			end
		end
	end

	// Clip test and row offset
	always_comb begin
		vis = !x_s1[C-1] && !y_s1[C-1]
			&& (CMP_W'(x_s1) < CMP_W'(cfg.screen_width))
			&& (CMP_W'(y_s1) < CMP_W'(cfg.screen_height));
		prod_full = $signed(y_s1) * $signed({1'b0, cfg.row_pitch_words});
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= emit;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (advance) begin
			x_s1     <= cur_x_q;
			y_s1     <= cur_y_q;
			color_s1 <= color_q;
			last_s1  <= fin;

			x_s2     <= x_s1;
			y_s2     <= y_s1;
			color_s2 <= color_s1;
			last_s2  <= last_s1;
			vis_s2   <= vis;
			prod_s2  <= {{(AW-PROD_W){prod_full[PROD_W-1]}}, prod_full};

			pixel.pixel_x      <= x_s2;
			pixel.pixel_y      <= y_s2;
			pixel.word_address <= cfg.frame_base + prod_s2
				+ {{(AW-C){x_s2[C-1]}}, x_s2};
			pixel.write_color  <= color_s2;
			pixel.visible      <= vis_s2;
			pixel.last         <= last_s2;
		end
	end

	assign pixel.valid = valid_s3;

endmodule

`default_nettype wire

FILE: rtl/core/line_rasterizer.sv
// Line rasterizer top level: configuration registers, front end, queue, back end.
//
// Channels: item (sink) takes start and tick commands, pixel (source) gives one
// pixel per tick of a line in progress, cfg (sink) writes the geometry
// registers screen_width, screen_height, row_pitch_words and frame_base.
// A start loads the end points and color and abandons any line in progress;
// it produces no pixel. A tick with no line in progress is dropped.
// Path: an accepted tick passes the front setup stage, queue, line walker,
// address multiply and address add, each registered, in that order.
// Throughput: one item per cycle, set by the line walker step, when pixel is not stalled.
// The front stage and a 4-entry queue keep item.ready high while the pixel
// side stalls, until the queue fills. While a pixel waits with pixel.ready
// low the back end holds its pipeline and output; no pixel is lost or repeated.
// Configuration writes are taken at any time (cfg.ready is always high) and
// must only happen while the block is idle.
// Reset clears the queue and pipeline, ends any line and loads the registers
// with 640, 480, 640 and 0.
`default_nettype none

module line_rasterizer #(
	parameter int COORD_BITS = 13
) (
	input  wire logic clk,
	input  wire logic arst_n,
	lr_item_if.sink   item,
	lr_pixel_if.source pixel,
	lr_cfg_if.sink    cfg
);

	localparam int C       = COORD_BITS;
	localparam int ENT_W   = 1 + C + C + (C + 1) + (C + 1) + 3 + lr_pkg::COLOR_W;

	lr_pkg::cfg_t               cfg_q;

	logic                       f_valid, f_action, f_x_neg, f_y_neg, f_x_major;
	logic [C-1:0]               f_x, f_y;
	logic [C:0]                 f_major, f_minor;
	logic [lr_pkg::COLOR_W-1:0] f_color;

	logic                       q_full, q_not_empty, q_pop;
	logic [ENT_W-1:0]           q_wr, q_rd;

	logic                       b_action, b_x_neg, b_y_neg, b_x_major;
	logic [C-1:0]               b_x, b_y;
	logic [C:0]                 b_major, b_minor;
	logic [lr_pkg::COLOR_W-1:0] b_color;

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width    <= lr_pkg::SCREEN_WIDTH_RST;
			cfg_q.screen_height   <= lr_pkg::SCREEN_HEIGHT_RST;
			cfg_q.row_pitch_words <= lr_pkg::ROW_PITCH_RST;
			cfg_q.frame_base      <= lr_pkg::FRAME_BASE_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				lr_pkg::CFG_SCREEN_WIDTH: begin
					cfg_q.screen_width <= cfg.data[lr_pkg::DIM_W-1:0];
				end
				lr_pkg::CFG_SCREEN_HEIGHT: begin
					cfg_q.screen_height <= cfg.data[lr_pkg::DIM_W-1:0];
				end
				lr_pkg::CFG_ROW_PITCH: begin
					cfg_q.row_pitch_words <= cfg.data[lr_pkg::PITCH_W-1:0];
				end
				lr_pkg::CFG_FRAME_BASE: begin
					cfg_q.frame_base <= cfg.data;
				end
				default: begin
				end
			endcase
		end
	end

	// Front end
	lr_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.ent_valid   (f_valid),
		.ent_ready   (!q_full),
		.ent_action  (f_action),
		.ent_x       (f_x),
		.ent_y       (f_y),
		.ent_major   (f_major),
		.ent_minor   (f_minor),
		.ent_x_neg   (f_x_neg),
		.ent_y_neg   (f_y_neg),
		.ent_x_major (f_x_major),
		.ent_color   (f_color)
	);

	// Command queue
	assign q_wr = {f_action, f_x, f_y, f_major, f_minor,
		f_x_neg, f_y_neg, f_x_major, f_color};

	lr_queue #(
		.WIDTH (ENT_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_valid),
		.wr_data   (q_wr),
		.full      (q_full),
		.pop       (q_pop),
		.rd_data   (q_rd),
		.not_empty (q_not_empty)
	);

	assign {b_action, b_x, b_y, b_major, b_minor,
		b_x_neg, b_y_neg, b_x_major, b_color} = q_rd;

	// Back end
	lr_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.ent_valid   (q_not_empty),
		.ent_pop     (q_pop),
		.ent_action  (b_action),
		.ent_x       (b_x),
		.ent_y       (b_y),
		.ent_major   (b_major),
		.ent_minor   (b_minor),
		.ent_x_neg   (b_x_neg),
		.ent_y_neg   (b_y_neg),
		.ent_x_major (b_x_major),
		.ent_color   (b_color),
		.pixel       (pixel)
	);

endmodule

`default_nettype wire
